// ----- rtl/dfjs_pkg.sv -----
package dfjs_pkg;

   localparam int MAX_SLOTS_DEF = 32;
   localparam int RESULT_CAP    = 32;

   localparam int JOB_COUNT_W = 6;
   localparam int DEADLINE_W  = 16;
   localparam int JOB_ID_W    = 16;
   localparam int KIND_W      = 2;
   localparam int SLOT_W      = 6;

   localparam logic [JOB_COUNT_W-1:0] JOB_COUNT_RST = 6'd32;

   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_EMIT  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_PLACE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

   typedef struct packed {
      logic                  op;
      logic [DEADLINE_W-1:0] deadline;
      logic [JOB_ID_W-1:0]   job_id;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic                placed;
      logic [SLOT_W-1:0]   slot;
      logic [JOB_ID_W-1:0] job_id_out;
      logic                last;
   } rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIND1 = 6'b000010,
      ST_FIND2 = 6'b000100,
      ST_EMIT  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   typedef struct packed {
      logic go;
      logic wr_en;
      logic clear_all;
   } fu_ctl_type;

   typedef struct packed {
      logic done;
      logic walking;
   } fu_sts_type;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } own_ctl_type;

endpackage

// ----- rtl/deadline_job_slot_scheduler_core.sv -----
// Place: a root find walks the parent links in the link memory, one link a cycle, from
// the limit slot; a second find then walks from the slot below that root. The reply
// strobes after both, or after the first for a refused job; busy is high until then.
// Emit: one owner memory read a cycle over all slots; busy through drain and flush.
// Results strobe for one cycle and the receiver cannot stall them.
// Synchronous reset clears the plan, the links and job_count (to 32) at once.
module deadline_job_slot_scheduler_core #(
   parameter int MAX_SLOTS = dfjs_pkg::MAX_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  dfjs_pkg::req_type                req_item,
   output logic                             rsp_strobe,
   output dfjs_pkg::rsp_type                rsp_item,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dfjs_pkg::JOB_COUNT_W-1:0] csr_wdata
);
   import dfjs_pkg::*;

   localparam int NODE_W = $clog2(MAX_SLOTS + 1);
   localparam int CNT_W  = $clog2(RESULT_CAP + 1);

   state_type            state_ff, state_in;
   logic [JOB_COUNT_W-1:0] job_count_ff;
   logic [JOB_ID_W-1:0]  job_id_ff, job_id_in;
   logic [NODE_W-1:0]    c1_ff, c1_in;
   logic [NODE_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [NODE_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [NODE_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [JOB_ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic [DEADLINE_W-1:0] cnt_lim;
   logic [DEADLINE_W-1:0] lim16;
   fu_ctl_type           fu_ctl;
   fu_sts_type           fu_sts;
   logic [NODE_W-1:0]    fu_root;
   logic [NODE_W-1:0]    find_node;
   own_ctl_type          own_ctl;
   logic [JOB_ID_W-1:0]  own_id;
   logic                 own_listed;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Limit is min(deadline, job_count, MAX_SLOTS).
   always_comb begin
      cnt_lim = (DEADLINE_W'(job_count_ff) < DEADLINE_W'(MAX_SLOTS)) ?
                DEADLINE_W'(job_count_ff) : DEADLINE_W'(MAX_SLOTS);
      lim16   = (req_item.deadline < cnt_lim) ? req_item.deadline : cnt_lim;
   end

   always_comb begin
      fu_ctl.go        = (accept && (req_item.op == OP_PLACE)) ||
                         ((state_ff == ST_FIND1) && fu_sts.done && (fu_root != '0));
      fu_ctl.wr_en     = (state_ff == ST_FIND2) && fu_sts.done;
      fu_ctl.clear_all = (state_ff == ST_FLUSH);
      find_node        = (state_ff == ST_FIND1) ? (fu_root - NODE_W'(1)) : NODE_W'(lim16);
      own_ctl.wr_en     = (state_ff == ST_FIND1) && fu_sts.done && (fu_root != '0);
      own_ctl.clear_all = (state_ff == ST_FLUSH);
   end

   dfjs_find_unit #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_find (
      .clock     (clock),
      .reset     (reset),
      .fu_ctl    (fu_ctl),
      .find_node (find_node),
      .wr_addr   (c1_ff),
      .wr_link   (fu_root),
      .fu_sts    (fu_sts),
      .root      (fu_root)
   );

   dfjs_owner_store #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_owner (
      .clock     (clock),
      .reset     (reset),
      .own_ctl   (own_ctl),
      .wr_addr   (fu_root),
      .wr_id     (job_id_ff),
      .rd_addr   (scan_idx_ff),
      .rd_id     (own_id),
      .rd_listed (own_listed)
   );

   always_comb begin
      state_in      = state_ff;
      job_id_in     = job_id_ff;
      c1_in         = c1_ff;
      scan_idx_in   = scan_idx_ff;
      rd_vld_in     = (state_ff == ST_EMIT);
      rd_idx_in     = scan_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      pend_id_in    = pend_id_ff;
      n_in          = n_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      // Plan entries are held back one step so the final one can carry last.
      if (rd_vld_ff && own_listed && (n_ff < CNT_W'(RESULT_CAP))) begin
         if (pend_vld_ff) begin
            rsp_strobe_in     = 1'b1;
            rsp_in.kind       = KIND_ENTRY;
            rsp_in.placed     = 1'b0;
            rsp_in.slot       = SLOT_W'(pend_idx_ff);
            rsp_in.job_id_out = pend_id_ff;
            rsp_in.last       = 1'b0;
         end
         pend_vld_in = 1'b1;
         pend_idx_in = rd_idx_ff;
         pend_id_in  = own_id;
         n_in        = n_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.op == OP_EMIT) begin
                  state_in    = ST_EMIT;
                  scan_idx_in = NODE_W'(1);
               end else begin
                  state_in  = ST_FIND1;
                  job_id_in = req_item.job_id;
               end
            end
         end
         ST_FIND1: begin
            if (fu_sts.done) begin
               if (fu_root == '0) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.kind       = KIND_PLACE;
                  rsp_in.placed     = 1'b0;
                  rsp_in.slot       = '0;
                  rsp_in.job_id_out = '0;
                  rsp_in.last       = 1'b1;
                  state_in          = ST_IDLE;
               end else begin
                  c1_in    = fu_root;
                  state_in = ST_FIND2;
               end
            end
         end
         ST_FIND2: begin
            if (fu_sts.done) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.kind       = KIND_PLACE;
               rsp_in.placed     = 1'b1;
               rsp_in.slot       = SLOT_W'(c1_ff);
               rsp_in.job_id_out = '0;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_EMIT: begin
            scan_idx_in = scan_idx_ff + NODE_W'(1);
            if (scan_idx_ff == NODE_W'(MAX_SLOTS)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_in.placed = 1'b0;
            rsp_in.last   = 1'b1;
            if (pend_vld_ff) begin
               rsp_in.kind       = KIND_ENTRY;
               rsp_in.slot       = SLOT_W'(pend_idx_ff);
               rsp_in.job_id_out = pend_id_ff;
            end else begin
               rsp_in.kind       = KIND_EMPTY;
               rsp_in.slot       = '0;
               rsp_in.job_id_out = '0;
            end
            pend_vld_in = 1'b0;
            n_in        = '0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         job_count_ff  <= JOB_COUNT_RST;
         rd_vld_ff     <= 1'b0;
         pend_vld_ff   <= 1'b0;
         n_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         pend_vld_ff   <= pend_vld_in;
         n_ff          <= n_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            job_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_id_ff   <= job_id_in;
      c1_ff       <= c1_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_id_ff  <= pend_id_in;
      rsp_ff      <= rsp_in;
   end

   a_walk_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !fu_sts.walking)
      else $error("root find active while idle");

   a_done_in_find_state: assert property (@(posedge clock) disable iff (reset)
      fu_sts.done |-> (state_ff == ST_FIND1 || state_ff == ST_FIND2))
      else $error("root find finished outside a find state");

   a_empty_from_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.kind == KIND_EMPTY) |-> $past(state_ff) == ST_FLUSH)
      else $error("empty plan result without an emit flush");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("plan entry left pending after emit");

endmodule

// ----- rtl/dfjs_find_unit.sv -----
module dfjs_find_unit #(
   parameter int MAX_SLOTS = dfjs_pkg::MAX_SLOTS_DEF,
   localparam int NODE_W = $clog2(MAX_SLOTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  dfjs_pkg::fu_ctl_type fu_ctl,
   input  logic [NODE_W-1:0]   find_node,
   input  logic [NODE_W-1:0]   wr_addr,
   input  logic [NODE_W-1:0]   wr_link,
   output dfjs_pkg::fu_sts_type fu_sts,
   output logic [NODE_W-1:0]   root
);
   import dfjs_pkg::*;

   logic [NODE_W-1:0] link_mem [0:MAX_SLOTS];
   logic [MAX_SLOTS:0] lnk_vld_ff;
   logic [NODE_W-1:0] link_rd_ff;
   logic              vld_rd_ff;
   logic [NODE_W-1:0] cur_ff;
   logic              walk_ff;
   logic              walk_in;
   logic [NODE_W-1:0] link_now;
   logic [NODE_W-1:0] rd_addr;
   logic              done;

   // A link never written still points at its own slot.
   assign link_now = vld_rd_ff ? link_rd_ff : cur_ff;
   assign done     = walk_ff && (link_now == cur_ff);
   assign rd_addr  = fu_ctl.go ? find_node : link_now;
   assign walk_in  = fu_ctl.go || (walk_ff && !done);

   assign fu_sts.done    = done;
   assign fu_sts.walking = walk_ff;
   assign root           = cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff    <= 1'b0;
         lnk_vld_ff <= '0;
      end else begin
         walk_ff <= walk_in;
         if (fu_ctl.clear_all) begin
            lnk_vld_ff <= '0;
         end else if (fu_ctl.wr_en) begin
            lnk_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fu_ctl.wr_en) begin
         link_mem[wr_addr] <= wr_link;
      end
      link_rd_ff <= link_mem[rd_addr];
      vld_rd_ff  <= lnk_vld_ff[rd_addr];
      cur_ff     <= rd_addr;
   end

endmodule

// ----- rtl/dfjs_owner_store.sv -----
module dfjs_owner_store #(
   parameter int MAX_SLOTS = dfjs_pkg::MAX_SLOTS_DEF,
   localparam int NODE_W = $clog2(MAX_SLOTS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dfjs_pkg::own_ctl_type          own_ctl,
   input  logic [NODE_W-1:0]              wr_addr,
   input  logic [dfjs_pkg::JOB_ID_W-1:0]  wr_id,
   input  logic [NODE_W-1:0]              rd_addr,
   output logic [dfjs_pkg::JOB_ID_W-1:0]  rd_id,
   output logic                           rd_listed
);
   import dfjs_pkg::*;

   logic [JOB_ID_W-1:0] owner_mem [0:MAX_SLOTS];
   logic [MAX_SLOTS:0]  occ_ff;
   logic [JOB_ID_W-1:0] rd_id_ff;
   logic                rd_occ_ff;

   // A slot taken by job id zero is occupied but is not listed.
   assign rd_id     = rd_id_ff;
   assign rd_listed = rd_occ_ff && (rd_id_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (own_ctl.clear_all) begin
         occ_ff <= '0;
      end else if (own_ctl.wr_en) begin
         occ_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (own_ctl.wr_en) begin
         owner_mem[wr_addr] <= wr_id;
      end
      rd_id_ff  <= owner_mem[rd_addr];
      rd_occ_ff <= occ_ff[rd_addr];
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import dfjs_pkg::*;

   localparam int SLOTS        = MAX_SLOTS_DEF;
   localparam int RANDOM_ITEMS = 400;

   // Models the slot table: greedy placement at the latest free slot, using
   // union-find sets whose root is the lowest slot of the set.
   class plan_scoreboard;
      logic [JOB_COUNT_W-1:0] job_count;
      logic [JOB_ID_W-1:0]    owner [0:SLOTS];
      int                     link [0:SLOTS];
      int                     free_top [0:SLOTS];
      rsp_type                pending [$];
      int                     mismatches;
      int                     results_seen;

      function new();
         job_count    = JOB_COUNT_RST;
         mismatches   = 0;
         results_seen = 0;
         clear_plan();
      endfunction

      function void clear_plan();
         for (int i = 0; i <= SLOTS; i++) begin
            owner[i]    = '0;
            link[i]     = i;
            free_top[i] = i;
         end
      endfunction

      // Finds the set root and flattens the path behind it.
      function int root_of(int x);
         int r;
         int cur;
         int nxt;
         r = x;
         while (link[r] != r)
            r = link[r];
         cur = x;
         while (cur != r) begin
            nxt       = link[cur];
            link[cur] = r;
            cur       = nxt;
         end
         return r;
      endfunction

      function void note_item(req_type item);
         int      lim;
         int      c1;
         int      c2;
         int      m;
         rsp_type r;
         rsp_type plan [$];
         r = '0;
         if (item.op == OP_PLACE) begin
            lim = (job_count < SLOTS) ? int'(job_count) : SLOTS;
            if (item.deadline < lim)
               lim = int'(item.deadline);
            c1     = root_of(lim);
            m      = free_top[c1];
            r.kind = KIND_PLACE;
            r.last = 1'b1;
            if (m != 0) begin
               owner[m]     = item.job_id;
               c2           = root_of(m - 1);
               link[c1]     = c2;
               free_top[c1] = free_top[c2];
               r.placed     = 1'b1;
               r.slot       = SLOT_W'(m);
            end
            pending.insert(pending.size(), r);
         end else begin
            for (int i = 1; i <= SLOTS; i++) begin
               if (owner[i] != 0 && plan.size() < RESULT_CAP) begin
                  r            = '0;
                  r.kind       = KIND_ENTRY;
                  r.slot       = SLOT_W'(i);
                  r.job_id_out = owner[i];
                  plan.insert(plan.size(), r);
               end
            end
            clear_plan();
            if (plan.size() == 0) begin
               r      = '0;
               r.kind = KIND_EMPTY;
            end else begin
               r = plan.pop_back();
            end
            r.last = 1'b1;
            plan.insert(plan.size(), r);
            foreach (plan[k])
               pending.insert(pending.size(), plan[k]);
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d slot %0d id %0h",
                                      got.kind, got.slot, got.job_id_out));
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.placed !== want.placed)
            report_mismatch($sformatf("placed %0b, expected %0b", got.placed, want.placed));
         if (got.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
         if (got.job_id_out !== want.job_id_out)
            report_mismatch($sformatf("job id %0h, expected %0h",
                                      got.job_id_out, want.job_id_out));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      endtask
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   req_type                req_item  = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [JOB_COUNT_W-1:0] csr_wdata = '0;

   plan_scoreboard plan_sb = new();
   int             items_sent   = 0;
   int             count_writes = 0;
   bit             burst        = 1'b0;

   deadline_job_slot_scheduler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         plan_sb.check_result(rsp_item);
   end

   // Leaves start high when the next item follows at once, so that start
   // never gets two assignments in one time step.
   task automatic send_item(req_type item);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      plan_sb.note_item(item);
      items_sent++;
   endtask

   task automatic place_job(int deadline, int id);
      req_type item;
      item.op       = OP_PLACE;
      item.deadline = DEADLINE_W'(deadline);
      item.job_id   = JOB_ID_W'(id);
      send_item(item);
   endtask

   task automatic emit_plan();
      req_type item;
      item.op       = OP_EMIT;
      item.deadline = DEADLINE_W'($urandom);
      item.job_id   = JOB_ID_W'($urandom);
      send_item(item);
   endtask

   // Waits for every expected result and for the block to drop busy.
   task automatic settle();
      start <= 1'b0;
      while (plan_sb.pending.size() != 0)
         @(posedge clock);
      do @(posedge clock); while (busy);
   endtask

   task automatic write_count(logic [JOB_COUNT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      plan_sb.job_count = value;
      count_writes++;
   endtask

   initial begin
      int                     target;
      int                     batch;
      int                     sel;
      int                     deadline;
      int                     id;
      logic [JOB_COUNT_W-1:0] cnt;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Job count is 32 out of reset.
      place_job(0, 16'h1234);
      place_job(16'hFFFF, 16'hFFFF);
      place_job(32, 16'h0001);
      place_job(1, 16'h8000);
      place_job(1, 16'h00AA);
      place_job(5, 0);
      place_job(5, 16'h5555);
      emit_plan();
      emit_plan();

      // With a count of zero every job is refused.
      write_count(0);
      place_job(10, 16'h0101);
      place_job(16'hFFFF, 16'h0202);
      emit_plan();

      // A count above the slot range clamps to the top slot; lowering it
      // afterwards must not hide the jobs already sitting up there.
      write_count(63);
      place_job(40, 16'hAAAA);
      place_job(16'h8000, 16'h0F0F);
      write_count(1);
      place_job(1, 16'hF0F0);
      place_job(2, 16'h3C3C);
      emit_plan();

      write_count(3);
      repeat (4) place_job(3, $urandom_range(1, 65535));
      emit_plan();

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 32;
            3: cnt = 63;
            default: cnt = JOB_COUNT_W'($urandom_range(0, 63));
         endcase
         write_count(cnt);
         burst = ($urandom_range(0, 3) == 0);
         batch = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 20);
         for (int j = 0; j < batch; j++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
               emit_plan();
            end else begin
               if (sel < 3)
                  deadline = $urandom_range(0, 65535);
               else
                  deadline = $urandom_range(0, (cnt > 32) ? 40 : cnt + 2);
               id = (sel == 3) ? 0 : $urandom_range(1, 65535);
               place_job(deadline, id);
            end
         end
         // Now and then the batch is left open and carries into the next count.
         if ($urandom_range(0, 4) != 0)
            emit_plan();
         burst = 1'b0;
      end

      settle();
      repeat (SLOTS + 8) @(posedge clock);
      $display("Sent %0d place and emit requests across %0d job count settings.",
               items_sent, count_writes + 1);
      $display("Compared %0d results; %0d mismatches, %0d results still outstanding.",
               plan_sb.results_seen, plan_sb.mismatches, plan_sb.pending.size());
      if (plan_sb.mismatches == 0 && plan_sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout: the run did not finish in the allowed time.");
      $display("Test completed with failures");
      $finish;
   end

endmodule
